@@ hdl/rgb_nearest_color_vote_defines.svh @@
// Assertion macros used by the checker file of the color vote block.
`ifndef RGB_NEAREST_COLOR_VOTE_DEFINES_SVH
`define RGB_NEAREST_COLOR_VOTE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define RNCV_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RNCV_ASSERT_NOW(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) (ant) |-> (cons)) \
      else $error(msg);

`endif

@@ hdl/rncv_pkg.sv @@
// Shared constants, codes and types of the color vote block.
package rncv_pkg;

   localparam int MaxColors     = 16;
   localparam int ColorIdxWidth = $clog2(MaxColors);
   localparam int CountWidth    = $clog2(MaxColors + 1);
   localparam int EntryIdxWidth = 4;
   localparam int RawWidth      = 16;
   localparam int ChanWidth     = 8;
   localparam int CentroidWidth = 3 * ChanWidth;
   localparam int WeightWidth   = 11;
   localparam int VoteWidth     = 16;
   localparam int ScoreWidth    = 16;
   localparam int DistWidth     = 18;
   localparam int NumWidth      = 25;
   localparam int RemWidth      = 24;
   localparam int StepWidth     = 4;
   localparam int ColorsCfgWidth = 5;
   localparam int CsrIdxWidth   = 3;
   localparam int CsrDataWidth  = 16;
   localparam int QueueDepth    = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [StepWidth-1:0] DivFirstStep = StepWidth'(ChanWidth);
   localparam logic [ChanWidth-1:0] ChanMax      = '1;
   localparam logic [VoteWidth-1:0] VoteMax      = '1;

   localparam logic OpLoad   = 1'b0;
   localparam logic OpSample = 1'b1;

   localparam logic [CsrIdxWidth-1:0] CsrRedLow     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrRedHigh    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrGreenLow   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrGreenHigh  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrBlueLow    = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrBlueHigh   = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CsrColorsUsed = 3'd6;

   typedef struct packed {
      logic                    write_enable;
      logic [CsrIdxWidth-1:0]  index;
      logic [CsrDataWidth-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic                          opcode;
      logic [EntryIdxWidth-1:0]      entry_index;
      logic [CentroidWidth-1:0]      centroid;
      logic signed [WeightWidth-1:0] weight;
      logic [ChanWidth-1:0]          scaled_red;
      logic [ChanWidth-1:0]          scaled_green;
      logic [ChanWidth-1:0]          scaled_blue;
      logic                          window_end;
   } item_type;

   typedef enum logic [1:0] {
      FrontIdle,
      FrontDivide,
      FrontPush
   } front_state_type;

   typedef enum logic [2:0] {
      BackIdle,
      BackScan,
      BackVote,
      BackTally,
      BackScore,
      BackOutput
   } back_state_type;

endpackage

@@ hdl/rncv_front.sv @@
// Front part: accepts items, scales sample channels with a serial divider.
module rncv_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rncv_pkg::csr_write_type                csr,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic [rncv_pkg::EntryIdxWidth-1:0]     req_entry_index,
   input  logic [rncv_pkg::ChanWidth-1:0]         req_centroid_red,
   input  logic [rncv_pkg::ChanWidth-1:0]         req_centroid_green,
   input  logic [rncv_pkg::ChanWidth-1:0]         req_centroid_blue,
   input  logic signed [rncv_pkg::WeightWidth-1:0] req_entry_weight,
   input  logic [rncv_pkg::RawWidth-1:0]          req_raw_red,
   input  logic [rncv_pkg::RawWidth-1:0]          req_raw_green,
   input  logic [rncv_pkg::RawWidth-1:0]          req_raw_blue,
   input  logic                                   req_window_end,
   output logic                                   push,
   output rncv_pkg::item_type                     push_item,
   input  logic                                   queue_full
);

   rncv_pkg::front_state_type state_ff, state_in;
   logic [rncv_pkg::StepWidth-1:0] step_ff;
   rncv_pkg::item_type item_ff;
   logic [rncv_pkg::RawWidth-1:0]  low_ff  [3];
   logic [rncv_pkg::RawWidth-1:0]  high_ff [3];
   logic [rncv_pkg::RemWidth-1:0]  rem_ff  [3];
   logic [rncv_pkg::RawWidth-1:0]  den_ff  [3];
   logic [rncv_pkg::ChanWidth-1:0] quo_ff  [3];
   logic [2:0] sat_ff, zero_ff;

   logic accept;
   logic [rncv_pkg::RawWidth-1:0]  raw [3];
   logic [rncv_pkg::RemWidth-1:0]  num_abs [3];
   logic [rncv_pkg::RawWidth-1:0]  den_abs [3];
   logic [2:0] force_zero, ge;
   logic [rncv_pkg::RemWidth-1:0]  den_shift [3];
   logic [rncv_pkg::ChanWidth-1:0] scaled [3];

   assign accept = req_valid && !req_stall;
   assign raw[0] = req_raw_red;
   assign raw[1] = req_raw_green;
   assign raw[2] = req_raw_blue;

   // operand setup: signed numerator (raw - low) * 255 and divisor high - low
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         logic signed [rncv_pkg::RawWidth:0]   diff;
         logic signed [rncv_pkg::RawWidth:0]   den;
         logic signed [rncv_pkg::NumWidth-1:0] num;
         diff = $signed({1'b0, raw[ch]}) - $signed({1'b0, low_ff[ch]});
         den  = $signed({1'b0, high_ff[ch]}) - $signed({1'b0, low_ff[ch]});
         num  = ($signed(rncv_pkg::NumWidth'(diff)) <<< 8) - rncv_pkg::NumWidth'(diff);
         force_zero[ch] = (den == '0) || (num[rncv_pkg::NumWidth-1] != den[rncv_pkg::RawWidth]);
         num_abs[ch] = num[rncv_pkg::NumWidth-1] ?
                       rncv_pkg::RemWidth'(-num) : rncv_pkg::RemWidth'(num);
         den_abs[ch] = den[rncv_pkg::RawWidth] ?
                       rncv_pkg::RawWidth'(-den) : rncv_pkg::RawWidth'(den);
         den_shift[ch] = rncv_pkg::RemWidth'(den_ff[ch]) << step_ff;
         ge[ch] = rem_ff[ch] >= den_shift[ch];
         scaled[ch] = zero_ff[ch] ? '0 : (sat_ff[ch] ? rncv_pkg::ChanMax : quo_ff[ch]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rncv_pkg::FrontIdle: begin
            if (accept) begin
               state_in = (req_opcode == rncv_pkg::OpLoad) ?
                          rncv_pkg::FrontPush : rncv_pkg::FrontDivide;
            end
         end
         rncv_pkg::FrontDivide: begin
            if (step_ff == '0) state_in = rncv_pkg::FrontPush;
         end
         rncv_pkg::FrontPush: begin
            if (!queue_full) state_in = rncv_pkg::FrontIdle;
         end
         default: state_in = rncv_pkg::FrontIdle;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != rncv_pkg::FrontIdle);
      push      = (state_ff == rncv_pkg::FrontPush) && !queue_full;
      push_item = item_ff;
      push_item.scaled_red   = scaled[0];
      push_item.scaled_green = scaled[1];
      push_item.scaled_blue  = scaled[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rncv_pkg::FrontIdle;
         for (int ch = 0; ch < 3; ch++) begin
            low_ff[ch]  <= '0;
            high_ff[ch] <= '1;
         end
      end else begin
         state_ff <= state_in;
         if (csr.write_enable) begin
            unique case (csr.index)
               rncv_pkg::CsrRedLow:    low_ff[0]  <= csr.data;
               rncv_pkg::CsrRedHigh:   high_ff[0] <= csr.data;
               rncv_pkg::CsrGreenLow:  low_ff[1]  <= csr.data;
               rncv_pkg::CsrGreenHigh: high_ff[1] <= csr.data;
               rncv_pkg::CsrBlueLow:   low_ff[2]  <= csr.data;
               rncv_pkg::CsrBlueHigh:  high_ff[2] <= csr.data;
               default: ;
            endcase
         end
      end
   end

   // restoring divide, one quotient bit per cycle; first step only checks >= 256
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.opcode      <= req_opcode;
         item_ff.entry_index <= req_entry_index;
         item_ff.centroid    <= {req_centroid_red, req_centroid_green, req_centroid_blue};
         item_ff.weight      <= req_entry_weight;
         item_ff.window_end  <= req_window_end;
         item_ff.scaled_red   <= '0;
         item_ff.scaled_green <= '0;
         item_ff.scaled_blue  <= '0;
         step_ff <= rncv_pkg::DivFirstStep;
         for (int ch = 0; ch < 3; ch++) begin
            rem_ff[ch]  <= num_abs[ch];
            den_ff[ch]  <= den_abs[ch];
            quo_ff[ch]  <= '0;
            sat_ff[ch]  <= 1'b0;
            zero_ff[ch] <= force_zero[ch];
         end
      end else if (state_ff == rncv_pkg::FrontDivide) begin
         step_ff <= step_ff - 1'b1;
         for (int ch = 0; ch < 3; ch++) begin
            if (step_ff == rncv_pkg::DivFirstStep) begin
               sat_ff[ch] <= ge[ch];
            end else if (ge[ch] && !sat_ff[ch]) begin
               rem_ff[ch] <= rem_ff[ch] - den_shift[ch];
               quo_ff[ch] <= quo_ff[ch] | (rncv_pkg::ChanWidth'(1) << step_ff[2:0]);
            end
         end
      end
   end

endmodule

@@ hdl/rncv_queue.sv @@
// Short queue of items between the front and back parts.
module rncv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rncv_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output rncv_pkg::item_type pop_item,
   output logic               empty
);

   rncv_pkg::item_type entry_ff [rncv_pkg::QueueDepth];
   logic [rncv_pkg::QueuePtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [rncv_pkg::QueueCntWidth-1:0] count_ff;

   assign full     = (count_ff == rncv_pkg::QueueCntWidth'(rncv_pkg::QueueDepth));
   assign empty    = (count_ff == '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

@@ hdl/rncv_back.sv @@
// Back part: centroid walk, vote count, window tally and running score.
module rncv_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  rncv_pkg::csr_write_type                 csr,
   input  logic                                    empty,
   input  rncv_pkg::item_type                      pop_item,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [rncv_pkg::EntryIdxWidth-1:0]      rsp_winning_color,
   output logic [rncv_pkg::VoteWidth-1:0]          rsp_winning_votes,
   output logic signed [rncv_pkg::ScoreWidth-1:0]  rsp_total_score
);

   rncv_pkg::back_state_type state_ff, state_in;
   rncv_pkg::item_type item_ff;
   logic [rncv_pkg::CentroidWidth-1:0]     centroid_ff [rncv_pkg::MaxColors];
   logic signed [rncv_pkg::WeightWidth-1:0] weight_ff  [rncv_pkg::MaxColors];
   logic [rncv_pkg::VoteWidth-1:0]         votes_ff    [rncv_pkg::MaxColors];
   logic signed [rncv_pkg::ScoreWidth-1:0] score_ff;
   logic [rncv_pkg::CountWidth-1:0]        colors_ff;
   logic [rncv_pkg::ColorIdxWidth-1:0]     walk_ff, best_ff;
   logic [rncv_pkg::DistWidth-1:0]         best_dist_ff;
   logic [rncv_pkg::VoteWidth-1:0]         best_votes_ff;
   logic [rncv_pkg::EntryIdxWidth-1:0]     out_color_ff;
   logic [rncv_pkg::VoteWidth-1:0]         out_votes_ff;

   logic walk_last, load_ok;
   logic [rncv_pkg::DistWidth-1:0] sq_dist;
   logic [rncv_pkg::VoteWidth-1:0] walk_votes;
   logic signed [rncv_pkg::ScoreWidth:0] score_sum;
   logic signed [rncv_pkg::ScoreWidth-1:0] score_sat;
   logic [rncv_pkg::CountWidth-1:0] colors_clamped;

   assign walk_last = (rncv_pkg::CountWidth'(walk_ff) + 1'b1 == colors_ff);
   assign load_ok   = (int'(pop_item.entry_index) < rncv_pkg::MaxColors);
   assign walk_votes = votes_ff[walk_ff];

   always_comb begin
      logic signed [rncv_pkg::ChanWidth:0] dr, dg, db;
      logic signed [rncv_pkg::DistWidth-1:0] pr, pg, pb;
      logic [rncv_pkg::CentroidWidth-1:0] c;
      c  = centroid_ff[walk_ff];
      dr = $signed({1'b0, item_ff.scaled_red})   - $signed({1'b0, c[23:16]});
      dg = $signed({1'b0, item_ff.scaled_green}) - $signed({1'b0, c[15:8]});
      db = $signed({1'b0, item_ff.scaled_blue})  - $signed({1'b0, c[7:0]});
      // squares formed at full width, differences sign-extended
      pr = dr * dr;
      pg = dg * dg;
      pb = db * db;
      sq_dist = unsigned'(pr) + unsigned'(pg) + unsigned'(pb);
   end

   always_comb begin
      score_sum = $signed({score_ff[rncv_pkg::ScoreWidth-1], score_ff}) +
                  (rncv_pkg::ScoreWidth+1)'(weight_ff[best_ff]);
      if (score_sum[rncv_pkg::ScoreWidth] != score_sum[rncv_pkg::ScoreWidth-1]) begin
         score_sat = score_sum[rncv_pkg::ScoreWidth] ?
                     {1'b1, {(rncv_pkg::ScoreWidth-1){1'b0}}} :
                     {1'b0, {(rncv_pkg::ScoreWidth-1){1'b1}}};
      end else begin
         score_sat = score_sum[rncv_pkg::ScoreWidth-1:0];
      end
   end

   always_comb begin
      if (csr.data[rncv_pkg::ColorsCfgWidth-1:0] == '0) begin
         colors_clamped = rncv_pkg::CountWidth'(1);
      end else if (int'(csr.data[rncv_pkg::ColorsCfgWidth-1:0]) > rncv_pkg::MaxColors) begin
         colors_clamped = rncv_pkg::CountWidth'(rncv_pkg::MaxColors);
      end else begin
         colors_clamped = rncv_pkg::CountWidth'(csr.data[rncv_pkg::ColorsCfgWidth-1:0]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rncv_pkg::BackIdle: begin
            if (!empty && pop_item.opcode == rncv_pkg::OpSample) state_in = rncv_pkg::BackScan;
         end
         rncv_pkg::BackScan: begin
            if (walk_last) state_in = rncv_pkg::BackVote;
         end
         rncv_pkg::BackVote: begin
            state_in = item_ff.window_end ? rncv_pkg::BackTally : rncv_pkg::BackIdle;
         end
         rncv_pkg::BackTally: begin
            if (walk_last) state_in = rncv_pkg::BackScore;
         end
         rncv_pkg::BackScore:  state_in = rncv_pkg::BackOutput;
         rncv_pkg::BackOutput: begin
            if (!rsp_stall) state_in = rncv_pkg::BackIdle;
         end
         default: state_in = rncv_pkg::BackIdle;
      endcase
   end

   always_comb begin
      pop       = (state_ff == rncv_pkg::BackIdle) && !empty;
      rsp_valid = (state_ff == rncv_pkg::BackOutput);
      rsp_winning_color = out_color_ff;
      rsp_winning_votes = out_votes_ff;
      rsp_total_score   = score_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rncv_pkg::BackIdle;
         score_ff  <= '0;
         colors_ff <= rncv_pkg::CountWidth'(1);
         for (int i = 0; i < rncv_pkg::MaxColors; i++) votes_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.write_enable && csr.index == rncv_pkg::CsrColorsUsed) colors_ff <= colors_clamped;
         if (state_ff == rncv_pkg::BackVote && votes_ff[best_ff] != rncv_pkg::VoteMax) begin
            votes_ff[best_ff] <= votes_ff[best_ff] + 1'b1;
         end
         if (state_ff == rncv_pkg::BackScore) begin
            score_ff <= score_sat;
            for (int i = 0; i < rncv_pkg::MaxColors; i++) votes_ff[i] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= pop_item;
         walk_ff <= '0;
         if (pop_item.opcode == rncv_pkg::OpLoad && load_ok) begin
            centroid_ff[rncv_pkg::ColorIdxWidth'(pop_item.entry_index)] <= pop_item.centroid;
            weight_ff[rncv_pkg::ColorIdxWidth'(pop_item.entry_index)]   <= pop_item.weight;
         end
      end
      if (state_ff == rncv_pkg::BackScan) begin
         walk_ff <= walk_ff + 1'b1;
         if (walk_ff == '0 || sq_dist < best_dist_ff) begin
            best_dist_ff <= sq_dist;
            best_ff      <= walk_ff;
         end
      end
      if (state_ff == rncv_pkg::BackVote) walk_ff <= '0;
      if (state_ff == rncv_pkg::BackTally) begin
         walk_ff <= walk_ff + 1'b1;
         if (walk_ff == '0 || walk_votes > best_votes_ff) begin
            best_votes_ff <= walk_votes;
            best_ff       <= walk_ff;
         end
      end
      if (state_ff == rncv_pkg::BackScore) begin
         out_color_ff <= rncv_pkg::EntryIdxWidth'(best_ff);
         out_votes_ff <= best_votes_ff;
      end
   end

endmodule

@@ hdl/rgb_nearest_color_vote.sv @@
// Top level of the nearest-centroid color classifier with window vote.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | opcode, entry, centroid, weight, raw rgb
//   rsp     | out       | rsp_valid / rsp_stall  | winning color, votes, total score
//   csr     | in        | csr_write_enable       | csr_index, csr_write_data
//
// Front: accept, then for a sample a divide (shift/subtract divider,
// one quotient bit per cycle, three channels side by side), then push.
// Back: a sample takes a centroid walk over the colors in use, then a vote;
// a window end adds a vote walk, score and output.
// Synchronous reset clears control, votes, score and config; color entries
// hold garbage until loaded. Stalled results hold the back part and can hold the front.
module rgb_nearest_color_vote (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [rncv_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [rncv_pkg::CsrDataWidth-1:0]       csr_write_data,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_opcode,
   input  logic [rncv_pkg::EntryIdxWidth-1:0]      req_entry_index,
   input  logic [rncv_pkg::ChanWidth-1:0]          req_centroid_red,
   input  logic [rncv_pkg::ChanWidth-1:0]          req_centroid_green,
   input  logic [rncv_pkg::ChanWidth-1:0]          req_centroid_blue,
   input  logic signed [rncv_pkg::WeightWidth-1:0] req_entry_weight,
   input  logic [rncv_pkg::RawWidth-1:0]           req_raw_red,
   input  logic [rncv_pkg::RawWidth-1:0]           req_raw_green,
   input  logic [rncv_pkg::RawWidth-1:0]           req_raw_blue,
   input  logic                                    req_window_end,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [rncv_pkg::EntryIdxWidth-1:0]      rsp_winning_color,
   output logic [rncv_pkg::VoteWidth-1:0]          rsp_winning_votes,
   output logic signed [rncv_pkg::ScoreWidth-1:0]  rsp_total_score
);

   rncv_pkg::csr_write_type csr;
   rncv_pkg::item_type      push_item, pop_item;
   logic push, pop, queue_full, queue_empty;

   // one write bundle feeds both halves; each decodes its own registers
   assign csr.write_enable = csr_write_enable;
   assign csr.index        = csr_index;
   assign csr.data         = csr_write_data;

   rncv_front u_front (
      .clock, .reset, .csr,
      .req_valid, .req_stall, .req_opcode, .req_entry_index,
      .req_centroid_red, .req_centroid_green, .req_centroid_blue,
      .req_entry_weight, .req_raw_red, .req_raw_green, .req_raw_blue,
      .req_window_end,
      .push, .push_item, .queue_full
   );

   // two entries let the front scale the next sample while the back walks
   rncv_queue u_queue (
      .clock, .reset,
      .push, .push_item, .full(queue_full),
      .pop, .pop_item, .empty(queue_empty)
   );

   rncv_back u_back (
      .clock, .reset, .csr,
      .empty(queue_empty), .pop_item, .pop,
      .rsp_valid, .rsp_stall,
      .rsp_winning_color, .rsp_winning_votes, .rsp_total_score
   );

endmodule

@@ hdl/rncv_checker.sv @@
// Port-level checker of the color vote block and its bind.
`include "rgb_nearest_color_vote_defines.svh"

module rncv_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic [rncv_pkg::EntryIdxWidth-1:0]      rsp_winning_color,
   input logic [rncv_pkg::VoteWidth-1:0]          rsp_winning_votes,
   input logic signed [rncv_pkg::ScoreWidth-1:0]  rsp_total_score
);

   `RNCV_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_winning_color) && $stable(rsp_winning_votes) && $stable(rsp_total_score), "result changed while stalled")
   `RNCV_ASSERT_NEXT(a_front_busy, req_valid && !req_stall, req_stall, "front took a second item at once")
   `RNCV_ASSERT_NEXT(a_rsp_once, rsp_valid && !rsp_stall, !rsp_valid, "result shown twice")
   `RNCV_ASSERT_NOW(a_reset_quiet, $past(reset) && !reset, !rsp_valid, "result right after reset")

endmodule

bind rgb_nearest_color_vote rncv_checker u_rncv_checker (.*);

@@ verif/tb.sv @@
// Self-checking testbench for the nearest-centroid color vote block.
`timescale 1ns / 1ps

module tb;

   // one input transfer as the sender offers it
   typedef struct {
      logic                                    opcode;
      logic [rncv_pkg::EntryIdxWidth-1:0]      entry_index;
      logic [rncv_pkg::ChanWidth-1:0]          cen_red;
      logic [rncv_pkg::ChanWidth-1:0]          cen_green;
      logic [rncv_pkg::ChanWidth-1:0]          cen_blue;
      logic signed [rncv_pkg::WeightWidth-1:0] weight;
      logic [rncv_pkg::RawWidth-1:0]           raw_red;
      logic [rncv_pkg::RawWidth-1:0]           raw_green;
      logic [rncv_pkg::RawWidth-1:0]           raw_blue;
      logic                                    window_end;
   } color_req_type;

   // one window verdict
   typedef struct {
      logic [rncv_pkg::EntryIdxWidth-1:0]     color;
      logic [rncv_pkg::VoteWidth-1:0]         votes;
      logic signed [rncv_pkg::ScoreWidth-1:0] score;
   } verdict_type;

   localparam int IdleLimit  = 5000; // cycles without any transfer
   localparam int DrainWait  = 60;   // longest back-end pass plus margin
   localparam int HoldCycles = 300;  // long receiver hold-off

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                    csr_write_enable = 1'b0;
   logic [rncv_pkg::CsrIdxWidth-1:0]        csr_index        = '0;
   logic [rncv_pkg::CsrDataWidth-1:0]       csr_write_data   = '0;
   logic                                    req_valid        = 1'b0;
   logic                                    req_stall;
   logic                                    req_opcode       = rncv_pkg::OpLoad;
   logic [rncv_pkg::EntryIdxWidth-1:0]      req_entry_index  = '0;
   logic [rncv_pkg::ChanWidth-1:0]          req_centroid_red   = '0;
   logic [rncv_pkg::ChanWidth-1:0]          req_centroid_green = '0;
   logic [rncv_pkg::ChanWidth-1:0]          req_centroid_blue  = '0;
   logic signed [rncv_pkg::WeightWidth-1:0] req_entry_weight = '0;
   logic [rncv_pkg::RawWidth-1:0]           req_raw_red      = '0;
   logic [rncv_pkg::RawWidth-1:0]           req_raw_green    = '0;
   logic [rncv_pkg::RawWidth-1:0]           req_raw_blue     = '0;
   logic                                    req_window_end   = 1'b0;
   logic                                    rsp_valid;
   logic                                    rsp_stall        = 1'b1;
   logic [rncv_pkg::EntryIdxWidth-1:0]      rsp_winning_color;
   logic [rncv_pkg::VoteWidth-1:0]          rsp_winning_votes;
   logic signed [rncv_pkg::ScoreWidth-1:0]  rsp_total_score;

   rgb_nearest_color_vote u_top (.*);

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // Shadow copy of the block's configuration and state
   // ---------------------------------------------------------------
   logic [rncv_pkg::RawWidth-1:0]           range_low [3];
   logic [rncv_pkg::RawWidth-1:0]           range_high[3];
   logic [rncv_pkg::ColorsCfgWidth-1:0]     colors_cfg;
   logic [rncv_pkg::ChanWidth-1:0]          shadow_centroid[rncv_pkg::MaxColors][3];
   logic signed [rncv_pkg::WeightWidth-1:0] shadow_weight[rncv_pkg::MaxColors];
   logic [rncv_pkg::VoteWidth-1:0]          shadow_votes[rncv_pkg::MaxColors];
   logic signed [rncv_pkg::ScoreWidth-1:0]  shadow_score;

   color_req_type pending_reqs[$];
   verdict_type   expected_verdicts[$];

   int  mismatches  = 0;
   int  n_samples   = 0;
   int  n_loads     = 0;
   int  n_windows   = 0;
   int  n_phases    = 0;
   int  idle_cycles = 0;
   logic req_taken  = 1'b0;
   logic rsp_taken  = 1'b0;
   int  gap_left    = 0;
   int  stall_left  = 0;
   logic hold_go    = 1'b0;
   logic hold_done  = 1'b0;
   int  hold_count  = 0;

   // linear map of a raw reading onto 0..255, truncation toward zero
   function automatic logic [rncv_pkg::ChanWidth-1:0] scale_reading(
         logic [rncv_pkg::RawWidth-1:0] raw,
         logic [rncv_pkg::RawWidth-1:0] lo,
         logic [rncv_pkg::RawWidth-1:0] hi);
      longint den, num, q;
      den = longint'(hi) - longint'(lo);
      if (den == 0) return '0;
      num = (longint'(raw) - longint'(lo)) * 255;
      q = num / den;
      if (q < 0) return '0;
      if (q > 255) return 8'd255;
      return rncv_pkg::ChanWidth'(q);
   endfunction

   // classify one accepted transfer; true when it closes a window
   function automatic bit classify_and_vote(color_req_type r, output verdict_type v);
      logic [rncv_pkg::ChanWidth-1:0] px[3];
      int n, best;
      longint d, best_d, diff, s;
      if (r.opcode == rncv_pkg::OpLoad) begin
         shadow_centroid[r.entry_index][0] = r.cen_red;
         shadow_centroid[r.entry_index][1] = r.cen_green;
         shadow_centroid[r.entry_index][2] = r.cen_blue;
         shadow_weight[r.entry_index] = r.weight;
         return 0;
      end
      px[0] = scale_reading(r.raw_red,   range_low[0], range_high[0]);
      px[1] = scale_reading(r.raw_green, range_low[1], range_high[1]);
      px[2] = scale_reading(r.raw_blue,  range_low[2], range_high[2]);
      n = (colors_cfg == 0) ? 1 :
          (colors_cfg > rncv_pkg::MaxColors) ? rncv_pkg::MaxColors : int'(colors_cfg);
      best = 0;
      best_d = 0;
      for (int i = 0; i < n; i++) begin
         d = 0;
         for (int c = 0; c < 3; c++) begin
            diff = longint'(px[c]) - longint'(shadow_centroid[i][c]);
            d += diff * diff;
         end
         if (i == 0 || d < best_d) begin
            best_d = d;
            best = i;
         end
      end
      if (shadow_votes[best] != rncv_pkg::VoteMax) shadow_votes[best]++;
      if (!r.window_end) return 0;
      best = 0;
      for (int i = 1; i < n; i++)
         if (shadow_votes[i] > shadow_votes[best]) best = i;
      s = longint'(shadow_score) + longint'(shadow_weight[best]);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      shadow_score = rncv_pkg::ScoreWidth'(s);
      v.color = rncv_pkg::EntryIdxWidth'(best);
      v.votes = shadow_votes[best];
      v.score = shadow_score;
      for (int i = 0; i < rncv_pkg::MaxColors; i++) shadow_votes[i] = '0;
      return 1;
   endfunction

   // ---------------------------------------------------------------
   // Driver: offers queued transfers with a random gap after each one
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      color_req_type r;
      bit send;
      send = 0;
      if (!reset) begin
         if (req_valid && req_taken) begin
            gap_left = $urandom_range(0, 8);
            send = (gap_left == 0 && pending_reqs.size() > 0);
            if (!send) req_valid <= 1'b0;
         end else if (!req_valid) begin
            if (gap_left > 0) gap_left--;
            else send = (pending_reqs.size() > 0);
         end
         if (send) begin
            r = pending_reqs.pop_front();
            req_opcode         <= r.opcode;
            req_entry_index    <= r.entry_index;
            req_centroid_red   <= r.cen_red;
            req_centroid_green <= r.cen_green;
            req_centroid_blue  <= r.cen_blue;
            req_entry_weight   <= r.weight;
            req_raw_red        <= r.raw_red;
            req_raw_green      <= r.raw_green;
            req_raw_blue       <= r.raw_blue;
            req_window_end     <= r.window_end;
            req_valid          <= 1'b1;
         end
      end
   end

   // Receiver: random stall per result, plus one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) stall_left = $urandom_range(0, 8);
         if (hold_go && !hold_done) rsp_stall <= 1'b1;
         else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   // hold-off length counted on its own
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_count++;
         if (hold_count >= HoldCycles) hold_done = 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: predicts on each input transfer, checks each result
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      color_req_type r;
      verdict_type   v, e;
      bit            req_xfer, rsp_xfer;
      req_xfer = !reset && req_valid && !req_stall;
      rsp_xfer = !reset && rsp_valid && !rsp_stall;
      req_taken <= req_xfer;
      rsp_taken <= rsp_xfer;
      if (req_xfer) begin
         r.opcode = req_opcode;         r.entry_index = req_entry_index;
         r.cen_red = req_centroid_red;  r.cen_green = req_centroid_green;
         r.cen_blue = req_centroid_blue; r.weight = req_entry_weight;
         r.raw_red = req_raw_red;       r.raw_green = req_raw_green;
         r.raw_blue = req_raw_blue;     r.window_end = req_window_end;
         if (r.opcode == rncv_pkg::OpLoad) n_loads++;
         else n_samples++;
         if (classify_and_vote(r, v)) expected_verdicts.push_back(v);
      end
      if (rsp_xfer) begin
         n_windows++;
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: color %0d votes %0d score %0d",
                        rsp_winning_color, rsp_winning_votes, rsp_total_score);
         end else begin
            e = expected_verdicts.pop_front();
            if (rsp_winning_color !== e.color || rsp_winning_votes !== e.votes ||
                rsp_total_score !== e.score) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: exp color %0d votes %0d score %0d, got %0d %0d %0d",
                           n_windows, e.color, e.votes, e.score, rsp_winning_color,
                           rsp_winning_votes, rsp_total_score);
            end
         end
      end
      // watchdog on transfers
      if (req_xfer || rsp_xfer || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("timeout: no transfer for %0d cycles", IdleLimit);
         $display("rgb_nearest_color_vote: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic add_load(int idx, int r, int g, int b, int w);
      color_req_type t;
      t = '{default: '0};
      t.opcode = rncv_pkg::OpLoad;
      t.entry_index = rncv_pkg::EntryIdxWidth'(idx);
      t.cen_red = rncv_pkg::ChanWidth'(r);
      t.cen_green = rncv_pkg::ChanWidth'(g);
      t.cen_blue = rncv_pkg::ChanWidth'(b);
      t.weight = rncv_pkg::WeightWidth'(w);
      t.raw_red = 16'($urandom); t.raw_green = 16'($urandom); t.raw_blue = 16'($urandom);
      t.window_end = 1'($urandom);
      pending_reqs.push_back(t);
   endtask

   task automatic add_sample(int r, int g, int b, bit we);
      color_req_type t;
      t = '{default: '0};
      t.opcode = rncv_pkg::OpSample;
      t.entry_index = rncv_pkg::EntryIdxWidth'($urandom);
      t.cen_red = 8'($urandom); t.cen_green = 8'($urandom); t.cen_blue = 8'($urandom);
      t.weight = rncv_pkg::WeightWidth'($urandom);
      t.raw_red = rncv_pkg::RawWidth'(r);
      t.raw_green = rncv_pkg::RawWidth'(g);
      t.raw_blue = rncv_pkg::RawWidth'(b);
      t.window_end = we;
      pending_reqs.push_back(t);
   endtask

   // register write, only while the block is idle
   task automatic write_reg(logic [rncv_pkg::CsrIdxWidth-1:0] idx, int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= rncv_pkg::CsrDataWidth'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         rncv_pkg::CsrRedLow:     range_low[0]  = rncv_pkg::RawWidth'(value);
         rncv_pkg::CsrRedHigh:    range_high[0] = rncv_pkg::RawWidth'(value);
         rncv_pkg::CsrGreenLow:   range_low[1]  = rncv_pkg::RawWidth'(value);
         rncv_pkg::CsrGreenHigh:  range_high[1] = rncv_pkg::RawWidth'(value);
         rncv_pkg::CsrBlueLow:    range_low[2]  = rncv_pkg::RawWidth'(value);
         rncv_pkg::CsrBlueHigh:   range_high[2] = rncv_pkg::RawWidth'(value);
         rncv_pkg::CsrColorsUsed: colors_cfg    = rncv_pkg::ColorsCfgWidth'(value);
         default: ;
      endcase
   endtask

   task automatic write_all(int rl, int rh, int gl, int gh, int bl, int bh, int n);
      write_reg(rncv_pkg::CsrRedLow, rl);    write_reg(rncv_pkg::CsrRedHigh, rh);
      write_reg(rncv_pkg::CsrGreenLow, gl);  write_reg(rncv_pkg::CsrGreenHigh, gh);
      write_reg(rncv_pkg::CsrBlueLow, bl);   write_reg(rncv_pkg::CsrBlueHigh, bh);
      write_reg(rncv_pkg::CsrColorsUsed, n);
      n_phases++;
   endtask

   // wait for all transfers and results, then let the back end drain
   task automatic drain_block();
      while (pending_reqs.size() > 0 || req_valid || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   // raw reading mostly inside the configured span, sometimes anywhere
   function automatic int pick_raw(int ch);
      int lo, hi;
      lo = (range_low[ch] < range_high[ch]) ? range_low[ch] : range_high[ch];
      hi = (range_low[ch] < range_high[ch]) ? range_high[ch] : range_low[ch];
      if ($urandom_range(0, 4) == 0) return $urandom_range(0, 65535);
      return $urandom_range(lo, hi);
   endfunction

   initial begin
      int weight_mode, we_pct;
      range_low  = '{0, 0, 0};
      range_high = '{65535, 65535, 65535};
      colors_cfg = 1;
      shadow_score = '0;
      for (int i = 0; i < rncv_pkg::MaxColors; i++) shadow_votes[i] = '0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: every entry loaded first, so no sample sees an unwritten one
      write_all(0, 65535, 0, 65535, 0, 65535, 16);
      add_load(0, 0, 0, 0, -1024);
      add_load(1, 0, 0, 0, 1023);          // same centroid as entry 0: distance tie
      add_load(2, 255, 255, 255, 1023);
      for (int i = 3; i < rncv_pkg::MaxColors; i++)
         add_load(i, i * 16, 255 - i * 16, (i * 37) % 256, i - 8);
      add_sample(0, 0, 0, 1);              // tie toward index 0
      add_sample(65535, 65535, 65535, 0);
      add_sample(0, 0, 0, 1);              // one vote each: lowest index wins
      add_sample(65535, 65535, 65535, 0);
      add_sample(65535, 65535, 65535, 0);
      add_sample(0, 65535, 0, 1);
      add_sample(65535, 0, 65535, 1);
      drain_block();

      // equal span on red, reversed span on green, colors of zero
      write_all(1000, 1000, 50000, 2000, 0, 65535, 0);
      add_sample(65535, 0, 30000, 1);
      add_sample(0, 65535, 1000, 1);
      drain_block();

      // random phases over several settings
      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: write_all(0, 65535, 0, 65535, 0, 65535, 16);
            1: write_all(500, 500, 65535, 0, 100, 900, 31);
            2: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 31));
            3: write_all(65535, 0, 0, 255, 65535, 65535, 1);
            default: write_all($urandom_range(0, 30000), $urandom_range(30000, 65535),
                               $urandom_range(0, 30000), $urandom_range(30000, 65535),
                               $urandom, $urandom, $urandom_range(0, 31));
         endcase
         // weights: random, all top (score saturates high) or all bottom
         weight_mode = (ph == 4) ? 1 : (ph == 5) ? 2 : 0;
         we_pct = (weight_mode != 0) ? 75 : 18;
         if (weight_mode != 0)
            for (int i = 0; i < rncv_pkg::MaxColors; i++)
               add_load(i, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), (weight_mode == 1) ? 1023 : -1024);
         if (ph == 3) hold_go = 1'b1;  // receiver holds off while sender keeps going
         for (int k = 0; k < 65; k++) begin
            if ($urandom_range(0, 99) < 12)
               add_load($urandom_range(0, 15), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        (weight_mode == 1) ? 1023 : (weight_mode == 2) ? -1024 :
                        int'($urandom_range(0, 2047)) - 1024);
            else
               add_sample(pick_raw(0), pick_raw(1), pick_raw(2),
                          $urandom_range(0, 99) < we_pct);
         end
         add_sample(pick_raw(0), pick_raw(1), pick_raw(2), 1);
         drain_block();
      end

      $display("covered %0d samples and %0d loads over %0d register settings",
               n_samples, n_loads, n_phases);
      $display("%0d window verdicts checked, %0d mismatches", n_windows, mismatches);
      if (mismatches == 0)
         $display("rgb_nearest_color_vote: match");
      else
         $display("rgb_nearest_color_vote: mismatch");
      $finish;
   end

endmodule
